// ----- src/lwma_pkg.sv -----
// Shared types, sizes and helper functions for the weighted moving average.
// No dependencies; every other file in src but lwma_ram refers to it by scoped names.
package lwma_pkg;

  localparam int MAX_WINDOW  = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int WS_BITS     = 6;
  localparam int WS_RESET    = 8;

  localparam int ADDR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int TRI_MAX = MAX_WINDOW * (MAX_WINDOW + 1) / 2;
  localparam int DIV_W   = (TRI_MAX > 1) ? $clog2(TRI_MAX + 1) : 1;
  localparam int SUM_W   = SAMPLE_BITS + DIV_W;
  localparam int PROD_W  = SAMPLE_BITS + WIN_W + 1;
  localparam int CNT_W   = $clog2(SUM_W + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [WS_BITS-1:0]            wsize_t;
  typedef logic [WIN_W-1:0]              win_t;
  typedef logic [ADDR_W-1:0]             addr_t;
  typedef logic [DIV_W-1:0]              divisor_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  // clamp the programmed size into 1..MAX_WINDOW
  function automatic win_t eff_window(wsize_t ws);
    win_t w;
    if (ws == '0) begin
      w = win_t'(1);
    end else if (int'(ws) > MAX_WINDOW) begin
      w = win_t'(MAX_WINDOW);
    end else begin
      w = win_t'(ws);
    end
    return w;
  endfunction

  // sum of weights 1..w
  function automatic divisor_t tri_num(win_t w);
    logic [2*WIN_W:0] p;
    p = ({{(WIN_W+1){1'b0}}, w} * {{WIN_W{1'b0}}, w + 1'b1}) >> 1;
    return divisor_t'(p);
  endfunction

endpackage

// ----- src/lwma_if.sv -----
// Valid/ready channel interfaces for sample and average words.
// Depends on lwma_pkg.
interface lwma_sample_if;
  logic              valid;
  logic              ready;
  lwma_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface lwma_average_if;
  logic              valid;
  logic              ready;
  lwma_pkg::sample_t average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

// ----- src/lwma_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module lwma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- src/lwma_mac.sv -----
// Shared multiply-accumulate unit: one tap per cycle, product registered
// before the add. Depends on lwma_pkg.
module lwma_mac (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  logic              issue_i,   // tap read issued this cycle
  input  lwma_pkg::win_t    weight_i,
  input  logic              live_i,    // slot holds a written sample
  input  lwma_pkg::sample_t rdata_i,   // RAM data for the tap issued the cycle before
  output logic              busy_o,
  output lwma_pkg::sum_t    acc_o
);
  logic                                   s1_q, s2_q;
  lwma_pkg::win_t                         w1_q;
  logic                                   live1_q;
  logic signed [lwma_pkg::PROD_W-1:0]     prod_q;
  lwma_pkg::sum_t                         acc_q;
  lwma_pkg::sample_t                      opnd;

  assign opnd = live1_q ? rdata_i : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      s1_q <= issue_i;
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w1_q    <= weight_i;
    live1_q <= live_i;
    prod_q  <= lwma_pkg::PROD_W'(opnd) * lwma_pkg::PROD_W'($signed({1'b0, w1_q}));
    if (clr_i) begin
      acc_q <= '0;
    end else if (s2_q) begin
      acc_q <= acc_q + lwma_pkg::SUM_W'(prod_q);
    end
  end

  assign busy_o = s1_q | s2_q;
  assign acc_o  = acc_q;
endmodule

// ----- src/lwma_div.sv -----
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// Depends on lwma_pkg.
module lwma_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  lwma_pkg::sum_t     dividend_i,
  input  lwma_pkg::divisor_t divisor_i,
  output logic               done_o,
  output lwma_pkg::sample_t  quotient_o
);
  localparam int SW = lwma_pkg::SUM_W;
  localparam int DW = lwma_pkg::DIV_W;

  logic                        busy_q;
  logic [lwma_pkg::CNT_W-1:0]  cnt_q;
  logic                        neg_q;
  logic [SW-1:0]               quo_q;
  logic [DW-1:0]               rem_q;
  logic [DW-1:0]               den_q;
  logic [DW:0]                 trial;
  logic                        fit;
  logic [SW-1:0]               res;

  assign trial = {rem_q, quo_q[SW-1]};
  assign fit   = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= lwma_pkg::CNT_W'(SW);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SW-1];
      quo_q <= dividend_i[SW-1] ? SW'(-dividend_i) : SW'(dividend_i);
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q && cnt_q != '0) begin
      rem_q <= fit ? DW'(trial - {1'b0, den_q}) : DW'(trial);
      quo_q <= {quo_q[SW-2:0], fit};
    end
  end

  assign res        = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = lwma_pkg::sample_t'(res[lwma_pkg::SAMPLE_BITS-1:0]);
endmodule

// ----- src/linear_weighted_moving_average.sv -----
// Top level of the linearly weighted moving average: sequencer, history RAM,
// shared MAC and serial divider. Depends on lwma_pkg, lwma_if, lwma_ram,
// lwma_mac and lwma_div.
//
//   port         dir  width  role
//   sample_i     in   16     signed sample word, valid/ready
//   average_o    out  16     signed weighted average word, valid/ready
//   cfg_we_i     in   1      window_size write strobe
//   cfg_wdata_i  in   6      window_size value (0 acts as 1, >32 as 32)
//
// Each word runs the MAC loop over the history RAM (one tap a cycle, W taps,
// W the clamped window size), then the 26-step restoring divide, then the
// load into the output register. sample_i.ready is high only when
// the sequencer is idle. A finished average sits in the output register, so a
// stalled average_o does not hold off the next sample; a second result waits
// in the divider until the register frees. Reset clears control state and the
// fill count; unwritten history slots read as zero through that count.
module linear_weighted_moving_average (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  lwma_sample_if.sink            sample_i,
  lwma_average_if.source         average_o,
  input  logic                   cfg_we_i,
  input  lwma_pkg::wsize_t       cfg_wdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_e;

  state_e state_q, state_d;

  lwma_pkg::wsize_t   ws_q;
  lwma_pkg::addr_t    wr_ptr_q, wr_ptr_d;
  lwma_pkg::addr_t    rd_ptr_q, rd_ptr_d;
  lwma_pkg::win_t     fill_q, fill_d;   // samples written, saturates
  lwma_pkg::win_t     w_q, w_d;         // window latched per word
  lwma_pkg::win_t     k_q, k_d;         // tap index, 0 = newest
  lwma_pkg::divisor_t tri_q, tri_d;

  logic               accept;
  logic               issue;
  logic               mac_busy;
  lwma_pkg::sum_t     acc;
  logic               div_start;
  logic               div_done;
  lwma_pkg::sample_t  quotient;
  lwma_pkg::sample_t  ram_rdata;

  logic               out_valid_q, out_valid_d;
  lwma_pkg::sample_t  avg_q;
  logic               out_free;
  logic               load;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign accept         = sample_i.valid && sample_i.ready;
  assign issue          = (state_q == ST_MAC) && (k_q != w_q);
  assign out_free       = !out_valid_q || average_o.ready;

  // sequencer
  always_comb begin
    state_d   = state_q;
    wr_ptr_d  = wr_ptr_q;
    rd_ptr_d  = rd_ptr_q;
    fill_d    = fill_q;
    w_d       = w_q;
    k_d       = k_q;
    tri_d     = tri_q;
    div_start = 1'b0;
    load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          wr_ptr_d = (wr_ptr_q == lwma_pkg::addr_t'(lwma_pkg::MAX_WINDOW - 1))
                     ? '0 : wr_ptr_q + 1'b1;
          rd_ptr_d = wr_ptr_q;
          if (fill_q != lwma_pkg::win_t'(lwma_pkg::MAX_WINDOW)) begin
            fill_d = fill_q + 1'b1;
          end
          w_d     = lwma_pkg::eff_window(ws_q);
          tri_d   = lwma_pkg::tri_num(lwma_pkg::eff_window(ws_q));
          k_d     = '0;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (issue) begin
          k_d      = k_q + 1'b1;
          rd_ptr_d = (rd_ptr_q == '0)
                     ? lwma_pkg::addr_t'(lwma_pkg::MAX_WINDOW - 1) : rd_ptr_q - 1'b1;
        end else if (!mac_busy) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (out_free) begin
            load    = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        // divider keeps its quotient until the next start
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (average_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ws_q        <= lwma_pkg::wsize_t'(lwma_pkg::WS_RESET);
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      fill_q      <= '0;
      w_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      fill_q      <= fill_d;
      w_q         <= w_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        ws_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tri_q <= tri_d;
    if (load) begin
      avg_q <= quotient;
    end
  end

  assign average_o.valid   = out_valid_q;
  assign average_o.average = avg_q;

  // history ring, newest word at wr_ptr - 1
  lwma_ram #(
    .WIDTH (lwma_pkg::SAMPLE_BITS),
    .DEPTH (lwma_pkg::MAX_WINDOW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wr_ptr_q),
    .wdata_i (sample_i.sample),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // weight of tap k is w - k; slots beyond the fill count count as zero
  lwma_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (accept),
    .issue_i  (issue),
    .weight_i (w_q - k_q),
    .live_i   (k_q < fill_q),
    .rdata_i  (ram_rdata),
    .busy_o   (mac_busy),
    .acc_o    (acc)
  );

  lwma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc),
    .divisor_i  (tri_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

endmodule

// ----- src/lwma_checker.sv -----
// Port-level checks for linear_weighted_moving_average, attached by bind.
// Depends on lwma_pkg and the top level's interface ports.
module lwma_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input lwma_pkg::sample_t out_data_i
);

  // one word in flight: ready drops right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("sample accepted while previous word in flight");

  // an average never appears the cycle after a sample is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !$rose(out_valid_i))
    else $error("average appeared too early");

  // a new average is loaded only as the sequencer returns to idle
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("average loaded while sequencer busy");

  // stalled average holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled average changed");

endmodule

bind linear_weighted_moving_average lwma_checker u_lwma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (average_o.valid),
  .out_ready_i (average_o.ready),
  .out_data_i  (average_o.average)
);

// ----- tb/sv/testbench.sv -----
// Self-checking bench for linear_weighted_moving_average: a directed table,
// then random phases, scored against typed averages or a cycle-free weighted-average predictor.
// Depends on lwma_pkg, lwma_if and the RTL under src.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Even with the widest window, 75% gaps and stalls on every word,
  // plus the long hold, a correct run stays well under this.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 2000;   // long receiver hold-off
  localparam int TAIL_CYCLES = 80;     // quiet time after the last average
  localparam int N_ROWS      = 25;
  localparam int N_PHASES    = 12;
  localparam int PHASE_WORDS = 150;

  typedef enum logic {ROW_WORD, ROW_SIZE} row_kind_e;
  typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_e;

  // One directed step: either a sample word or a window_size write. A row
  // with known set carries its average typed in; others use the predictor.
  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] value;
    logic        known;
    logic [15:0] avg;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  lwma_pkg::wsize_t cfg_wdata_i;

  lwma_sample_if  s_if ();
  lwma_average_if a_if ();

  linear_weighted_moving_average u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (s_if),
    .average_o   (a_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: our own copy of the sample history (slot 0 newest)
  // and of the programmed window size.
  // ---------------------------------------------------------------------
  lwma_pkg::sample_t sample_hist [lwma_pkg::MAX_WINDOW];
  lwma_pkg::wsize_t  window_reg;
  lwma_pkg::sample_t pending_averages [$];  // averages owed by the block, oldest first

  int  fail_count   = 0;
  int  cycle_count  = 0;
  int  src_idle_pct = 0;
  int  snk_stall_pct = 0;
  logic rx_hold     = 1'b0;
  event hold_start;

  // Shift the new word in and form the weighted average over the clamped
  // window. Zero window acts as one; anything above MAX_WINDOW saturates.
  // SV integer division truncates toward zero, which is what we want.
  function automatic lwma_pkg::sample_t next_average(lwma_pkg::sample_t s);
    int     w;
    longint acc;
    longint weight_sum;
    w = int'(window_reg);
    if (w < 1) w = 1;
    if (w > lwma_pkg::MAX_WINDOW) w = lwma_pkg::MAX_WINDOW;
    for (int k = lwma_pkg::MAX_WINDOW - 1; k > 0; k--) sample_hist[k] = sample_hist[k-1];
    sample_hist[0] = s;
    acc = 0;
    for (int k = 0; k < w; k++) acc += longint'(sample_hist[k]) * (w - k);
    weight_sum = (w * (w + 1)) / 2;
    return lwma_pkg::sample_t'(acc / weight_sum);
  endfunction

  // Append an owed average at the tail of the queue.
  function automatic void owe_average(lwma_pkg::sample_t v);
    pending_averages.insert(pending_averages.size(), v);
  endfunction

  task automatic note_fail(string what, lwma_pkg::sample_t want, lwma_pkg::sample_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] %s: expected %0d (0x%h), got %0d (0x%h)",
               $realtime, what, want, want, got, got);
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: scores every accepted average, then picks next ready.
  // Values are read at the edge, before any flop update lands.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && a_if.valid && a_if.ready) begin
      if (pending_averages.size() == 0) begin
        note_fail("average with none owed", '0, a_if.average);
      end else if (a_if.average !== pending_averages[0]) begin
        note_fail("average mismatch", pending_averages[0], a_if.average);
        void'(pending_averages.pop_front());
      end else begin
        void'(pending_averages.pop_front());
      end
    end
    a_if.ready <= !rx_hold && ($urandom_range(99) >= snk_stall_pct);
  end

  // Long hold-off of the receiver, counted here so the sender keeps pushing
  // words into a block that fills up and drops its input ready.
  initial begin
    forever begin
      @(hold_start);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      rx_hold <= 1'b0;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d averages still owed",
               cycle_count, pending_averages.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offer one word, with random idle cycles ahead of it. Returns in the time
  // step of acceptance, with valid still high so back-to-back words work.
  task automatic offer_word(lwma_pkg::sample_t s, logic known,
                            lwma_pkg::sample_t typed_avg);
    lwma_pkg::sample_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      s_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    s_if.valid  <= 1'b1;
    s_if.sample <= s;
    do @(posedge clk_i); while (!s_if.ready);
    predicted = next_average(s);
    owe_average(known ? typed_avg : predicted);
  endtask

  // Stop offering and let every owed average come back. Checked on the
  // falling edge so the receiver's pop on the rising edge has settled.
  task automatic drain;
    s_if.valid <= 1'b0;
    while (pending_averages.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // window_size may only change with the block idle.
  task automatic write_window(lwma_pkg::wsize_t v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    window_reg   = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic lwma_pkg::sample_t pick_sample();
    case ($urandom_range(7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return lwma_pkg::sample_t'(int'($urandom_range(31)) - 16);
      default: return lwma_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic set_pace(pace_e p);
    case (p)
      PACE_FULL:      begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      PACE_SRC_IDLE:  begin src_idle_pct = 75; snk_stall_pct = 0;  end
      PACE_SNK_STALL: begin src_idle_pct = 0;  snk_stall_pct = 75; end
      default:        begin src_idle_pct = 19; snk_stall_pct = 19; end
    endcase
  endtask

  // Directed words. Typed averages are the ones obvious by eye: zero history
  // after reset, window of one (or zero, which acts as one) passing the word
  // straight through, and a small negative sum truncating toward zero.
  row_t dir_rows [N_ROWS] = '{
    '{ROW_WORD, 16'h0000, 1'b1, 16'h0000},  // reset: window 8, all zeros
    '{ROW_WORD, 16'h7fff, 1'b0, 16'h0000},
    '{ROW_WORD, 16'h8000, 1'b0, 16'h0000},
    '{ROW_SIZE, 16'd1,    1'b0, 16'h0000},
    '{ROW_WORD, 16'h7fff, 1'b1, 16'h7fff},
    '{ROW_WORD, 16'h8000, 1'b1, 16'h8000},
    '{ROW_WORD, 16'hffff, 1'b1, 16'hffff},
    '{ROW_WORD, 16'h0001, 1'b1, 16'h0001},
    '{ROW_SIZE, 16'd0,    1'b0, 16'h0000},  // zero acts as one
    '{ROW_WORD, 16'h3039, 1'b1, 16'h3039},
    '{ROW_WORD, 16'h8000, 1'b1, 16'h8000},
    '{ROW_SIZE, 16'd2,    1'b0, 16'h0000},
    '{ROW_WORD, 16'h0000, 1'b0, 16'h0000},
    '{ROW_WORD, 16'hffff, 1'b1, 16'h0000},  // -2/3 truncates to zero
    '{ROW_WORD, 16'h0001, 1'b0, 16'h0000},
    '{ROW_SIZE, 16'd63,   1'b0, 16'h0000},  // saturates at MAX_WINDOW
    '{ROW_WORD, 16'h7fff, 1'b0, 16'h0000},
    '{ROW_WORD, 16'h7fff, 1'b0, 16'h0000},
    '{ROW_SIZE, 16'd33,   1'b0, 16'h0000},
    '{ROW_WORD, 16'h8000, 1'b0, 16'h0000},
    '{ROW_SIZE, 16'd4,    1'b0, 16'h0000},  // shrink, history kept
    '{ROW_WORD, 16'h1234, 1'b0, 16'h0000},
    '{ROW_SIZE, 16'd32,   1'b0, 16'h0000},
    '{ROW_WORD, 16'h8000, 1'b0, 16'h0000},
    '{ROW_WORD, 16'h7fff, 1'b0, 16'h0000}
  };

  lwma_pkg::wsize_t phase_sizes [N_PHASES] = '{
    6'd1, 6'd32, 6'd8, 6'd63, 6'd0, 6'd2, 6'd33, 6'd17, 6'd31, 6'd3, 6'd5, 6'd12
  };

  initial begin
    lwma_pkg::wsize_t ws;
    // every input known from time zero
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    s_if.valid  = 1'b0;
    s_if.sample = '0;
    a_if.ready  = 1'b0;
    window_reg  = lwma_pkg::wsize_t'(lwma_pkg::WS_RESET);
    foreach (sample_hist[k]) sample_hist[k] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at full pace.
    set_pace(PACE_FULL);
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_SIZE) begin
        write_window(lwma_pkg::wsize_t'(dir_rows[r].value));
      end else begin
        offer_word(lwma_pkg::sample_t'(dir_rows[r].value), dir_rows[r].known,
                   lwma_pkg::sample_t'(dir_rows[r].avg));
      end
    end

    // Random phases: new window each time, pacing rotates through all modes.
    for (int p = 0; p < N_PHASES; p++) begin
      ws = phase_sizes[p];
      if (p == 8 || p == 11) ws = lwma_pkg::wsize_t'($urandom_range(63));
      write_window(ws);
      set_pace(pace_e'(p % 4));
      // phase 4 runs at full pace into a receiver held off for a long time
      if (p == 4) ->hold_start;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // sender pause until everything owed has come back
        if (p == 6 && i == PHASE_WORDS / 2) drain();
        offer_word(pick_sample(), 1'b0, '0);
      end
    end

    drain();
    set_pace(PACE_FULL);
    // any stray average in this window is flagged by the receiver
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending_averages.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
